// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the ARP responder (used by its top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/arp_pkg.sv =====
// Types and constants of the ARP responder.
`default_nettype none

package arp_pkg;

  // Input item: received ARP frame or resolve query
  typedef struct packed {
    logic        action;
    logic [15:0] arp_op;
    logic [15:0] protocol;
    logic [47:0] sender_hw;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [47:0] frame_src_hw;
  } in_item_t;

  // Result item: binding to the IP layer or frame to transmit
  typedef struct packed {
    logic        kind;
    logic [47:0] eth_dest;
    logic [1:0]  out_op;
    logic [47:0] out_sender_hw;
    logic [31:0] out_sender_ip;
    logic [47:0] out_target_hw;
    logic [31:0] out_target_ip;
    logic [31:0] bind_ip;
    logic [47:0] bind_hw;
    logic        forgery_alert;
    logic        last;
  } out_item_t;

  // Configuration registers as seen by the decision logic
  typedef struct packed {
    logic [31:0] my_ip;
    logic [47:0] my_hw;
    logic [31:0] peer_ip;
    logic [31:0] broadcast_ip;
    logic [31:0] subnet_mask;
    logic        proxy_enable;
    logic        fool_enable;
  } cfg_t;

  // Up to two results per input item, with their count
  typedef struct packed {
    out_item_t   res0;
    out_item_t   res1;
    logic [1:0]  count;
  } dec_t;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_MY_IP        = 3'd0;
  localparam logic [2:0] CFG_MY_HW        = 3'd1;
  localparam logic [2:0] CFG_PEER_IP      = 3'd2;
  localparam logic [2:0] CFG_BROADCAST_IP = 3'd3;
  localparam logic [2:0] CFG_SUBNET_MASK  = 3'd4;
  localparam logic [2:0] CFG_PROXY_ENABLE = 3'd5;
  localparam logic [2:0] CFG_FOOL_ENABLE  = 3'd6;

  // Protocol codes
  localparam logic        ACTION_QUERY   = 1'b1;
  localparam logic [15:0] PROTO_IP       = 16'h0800;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [1:0]  OUT_OP_REQUEST = 2'd1;
  localparam logic [1:0]  OUT_OP_REPLY   = 2'd2;
  localparam logic        KIND_BIND      = 1'b0;
  localparam logic        KIND_FRAME     = 1'b1;
  localparam logic [47:0] HW_BROADCAST   = 48'hFFFF_FFFF_FFFF;
  localparam logic [7:0]  CLASS_C_HOST   = 8'hFF;

  localparam logic [1:0]  COUNT_NONE = 2'd0;
  localparam logic [1:0]  COUNT_ONE  = 2'd1;
  localparam logic [1:0]  COUNT_TWO  = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/arp_decide.sv =====
// Decision logic: turns one ARP frame or query into zero, one or two results.
`default_nettype none

module arp_decide (
  input  wire arp_pkg::in_item_t item,
  input  wire arp_pkg::cfg_t     cfg,
  output arp_pkg::dec_t          dec
);
  import arp_pkg::*;

  // Classful network part of an address
  function automatic logic [31:0] net_part(input logic [31:0] a);
    logic [31:0] n;
    if (!a[31])                  n = a & 32'hFF00_0000;
    else if (a[31:30] == 2'b10)  n = a & 32'hFFFF_0000;
    else if (a[31:29] == 3'b110) n = a & ~{24'h0, CLASS_C_HOST};
    else                         n = a;
    return n;
  endfunction

  // Subnet part; a zero mask falls back to classful masking
  function automatic logic [31:0] subnet_part(input logic [31:0] a,
                                              input logic [31:0] m);
    logic [31:0] s;
    s = (m != 32'd0) ? (a & m) : net_part(a);
    return s;
  endfunction

  function automatic out_item_t make_bind(input logic [31:0] ip,
                                          input logic [47:0] hw);
    out_item_t r;
    r         = '0;
    r.kind    = KIND_BIND;
    r.bind_ip = ip;
    r.bind_hw = hw;
    return r;
  endfunction

  function automatic out_item_t make_frame(input logic [47:0] dst,
                                           input logic [1:0]  op,
                                           input logic [47:0] shw,
                                           input logic [31:0] sip,
                                           input logic [47:0] thw,
                                           input logic [31:0] tip,
                                           input logic        alert);
    out_item_t r;
    r               = '0;
    r.kind          = KIND_FRAME;
    r.eth_dest      = dst;
    r.out_op        = op;
    r.out_sender_hw = shw;
    r.out_sender_ip = sip;
    r.out_target_hw = thw;
    r.out_target_ip = tip;
    r.forgery_alert = alert;
    return r;
  endfunction

  logic tgt_me, tgt_peer_bc, forged, proxy;

  assign tgt_me      = item.target_ip == cfg.my_ip;
  assign tgt_peer_bc = (item.target_ip == cfg.peer_ip) ||
                       (item.target_ip == cfg.broadcast_ip);
  assign forged      = (item.sender_hw != cfg.my_hw) && (item.sender_ip == cfg.my_ip);
  assign proxy       = cfg.proxy_enable &&
                       (net_part(item.target_ip) == net_part(cfg.my_ip)) &&
                       (subnet_part(item.target_ip, cfg.subnet_mask) !=
                        subnet_part(cfg.my_ip, cfg.subnet_mask));

  // Result selection
  always_comb begin
    dec = '0;
    if (item.action == ACTION_QUERY) begin
      dec.count = COUNT_ONE;
      if (tgt_me) begin
        dec.res0 = make_bind(item.target_ip, cfg.my_hw);
      end else if (tgt_peer_bc) begin
        dec.res0 = make_bind(item.target_ip, HW_BROADCAST);
      end else begin
        dec.res0 = make_frame(HW_BROADCAST, OUT_OP_REQUEST, cfg.my_hw, cfg.my_ip,
                              48'd0, item.target_ip, 1'b0);
      end
    end else if (item.protocol != PROTO_IP) begin
      dec.count = COUNT_NONE;
    end else if (forged) begin
      // corrective broadcast reply, no binding
      dec.count = COUNT_ONE;
      dec.res0  = make_frame(HW_BROADCAST, OUT_OP_REPLY, cfg.my_hw, cfg.my_ip,
                             cfg.my_hw, cfg.my_ip, 1'b1);
    end else begin
      dec.count = COUNT_ONE;
      dec.res0  = make_bind(item.sender_ip, item.sender_hw);
      if (item.arp_op == ARP_OP_REQUEST) begin
        if (tgt_me || proxy) begin
          dec.count = COUNT_TWO;
          dec.res1  = make_frame(HW_BROADCAST, OUT_OP_REPLY, cfg.my_hw,
                                 item.target_ip, item.sender_hw, item.sender_ip, 1'b0);
        end else if (tgt_peer_bc && cfg.fool_enable) begin
          dec.count = COUNT_TWO;
          dec.res1  = make_frame(item.frame_src_hw, OUT_OP_REPLY, 48'd0,
                                 item.target_ip, item.sender_hw, item.sender_ip, 1'b0);
        end
      end
    end
    dec.res0.last = dec.count == COUNT_ONE;
    dec.res1.last = 1'b1;
  end

endmodule

`default_nettype wire

// ===== hdl/arp_responder_unit.sv =====
// Top level of the ARP responder: input register, decision, result register.
// A result passes from the input register through the decision logic into the
// result register, which is shared by both results of an item. Throughput: one
// item per cycle while the result side does not stall and it gives at most one
// result; an item with two results holds the input register until both load.
// Reset clears the valid flags, the result index and all configuration registers.
`default_nettype none

module arp_responder_unit (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_stall,
  input  wire arp_pkg::in_item_t item,
  output logic                result_valid,
  input  wire                 result_stall,
  output arp_pkg::out_item_t  result,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [2:0]           cfg_index,
  input  wire [47:0]          cfg_data
);
  import arp_pkg::*;

  `include "assert_macros.svh"

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_idx;
  dec_t      dec;
  out_item_t sel;
  logic      out_free, out_load, s1_adv, item_take;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MY_IP:        cfg.my_ip        <= cfg_data[31:0];
        CFG_MY_HW:        cfg.my_hw        <= cfg_data;
        CFG_PEER_IP:      cfg.peer_ip      <= cfg_data[31:0];
        CFG_BROADCAST_IP: cfg.broadcast_ip <= cfg_data[31:0];
        CFG_SUBNET_MASK:  cfg.subnet_mask  <= cfg_data[31:0];
        CFG_PROXY_ENABLE: cfg.proxy_enable <= cfg_data[0];
        CFG_FOOL_ENABLE:  cfg.fool_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  arp_decide u_decide (
    .item (s1_item),
    .cfg  (cfg),
    .dec  (dec)
  );

  // Handshake: the held item leaves once its last result moves out, or at once if it gives none
  assign sel        = s1_idx ? dec.res1 : dec.res0;
  assign out_free   = !result_valid || !result_stall;
  assign out_load   = s1_valid && (dec.count != COUNT_NONE) && out_free;
  assign s1_adv     = s1_valid && ((dec.count == COUNT_NONE) || (out_load && sel.last));
  assign item_stall = s1_valid && !s1_adv;
  assign item_take  = item_valid && !item_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_idx   <= 1'b0;
    end else begin
      if (item_take)   s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
      if (item_take || s1_adv) s1_idx <= 1'b0;
      else if (out_load)       s1_idx <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) s1_item <= item;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) result <= sel;
  end

  // Checks
  `AST_IMPL(a_no_stall_empty, !s1_valid, !item_stall, "stall with empty input register")
  `AST_IMPL(a_idx_two, s1_valid && s1_idx, dec.count == COUNT_TWO,
            "second result index on an item without two results")
  `AST_IMPL(a_idx_idle, !s1_valid, !s1_idx, "result index set with no item held")
  `AST_NEXT(a_first_holds, out_load && !sel.last, s1_valid && s1_idx,
            "item left before its second result")

endmodule

`default_nettype wire

// ===== bench/arp_responder_unit_test.sv =====
// Self-checking bench for the ARP responder: random idling, config phases, result prediction.
`default_nettype none

module arp_responder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import arp_pkg::*;

  localparam logic        ACTION_FRAME  = 1'b0;
  localparam logic [15:0] ARP_OP_REPLY  = 16'd2;
  localparam logic [15:0] PROTO_IPV6    = 16'h86DD;
  localparam logic [2:0]  CFG_UNUSED    = 3'd7;
  localparam int          MAX_SHOWN     = 10;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLDOFF_LEN   = 120;
  localparam int          STUCK_LIMIT   = 3000;
  localparam int          ITEMS_PER_PHASE = 183;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  in_item_t    item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_item_t   result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  // pending ARP inputs and predicted outputs
  in_item_t  arp_inputs_q[$];
  out_item_t arp_results_q[$];
  cfg_t      cfg_now = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pressure_req = 0;
  int pressure_done = 0;
  int holdoff_left = 0;
  int mismatches = 0;
  int results_seen = 0;
  int stuck_cycles = 0;

  arp_responder_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // classful network part: A keeps 8 bits, B 16, C 24, others whole
  function automatic logic [31:0] classful_net(input logic [31:0] a);
    if (!a[31]) return {a[31:24], 24'h0};
    if (a[31:30] == 2'b10) return {a[31:16], 16'h0};
    if (a[31:29] == 3'b110) return a & ~{24'h0, CLASS_C_HOST};
    return a;
  endfunction

  function automatic logic [31:0] subnet_of(input logic [31:0] a, input logic [31:0] mask);
    return (mask != '0) ? (a & mask) : classful_net(a);
  endfunction

  function automatic out_item_t binding(input logic [31:0] ip, input logic [47:0] hw);
    out_item_t o;
    o = '0;
    o.kind    = KIND_BIND;
    o.bind_ip = ip;
    o.bind_hw = hw;
    return o;
  endfunction

  function automatic out_item_t arp_frame(input logic [47:0] dst, input logic [1:0] op,
                                          input logic [47:0] shw, input logic [31:0] sip,
                                          input logic [47:0] thw, input logic [31:0] tip,
                                          input logic alert);
    out_item_t o;
    o = '0;
    o.kind          = KIND_FRAME;
    o.eth_dest      = dst;
    o.out_op        = op;
    o.out_sender_hw = shw;
    o.out_sender_ip = sip;
    o.out_target_hw = thw;
    o.out_target_ip = tip;
    o.forgery_alert = alert;
    return o;
  endfunction

  // Expected outputs of one ARP input; returns how many there are
  function automatic int predict_arp(input in_item_t it, input cfg_t c,
                                     output out_item_t r0, output out_item_t r1);
    logic proxy_hit;
    r0 = '0;
    r1 = '0;
    if (it.action == ACTION_QUERY) begin
      if (it.target_ip == c.my_ip) begin
        r0 = binding(it.target_ip, c.my_hw);
      end else if (it.target_ip == c.peer_ip || it.target_ip == c.broadcast_ip) begin
        r0 = binding(it.target_ip, HW_BROADCAST);
      end else begin
        r0 = arp_frame(HW_BROADCAST, OUT_OP_REQUEST, c.my_hw, c.my_ip, '0,
                       it.target_ip, 1'b0);
      end
      r0.last = 1'b1;
      return 1;
    end
    if (it.protocol != PROTO_IP) return 0;
    // someone else claims our address: broadcast a correction, no binding
    if (it.sender_hw != c.my_hw && it.sender_ip == c.my_ip) begin
      r0 = arp_frame(HW_BROADCAST, OUT_OP_REPLY, c.my_hw, c.my_ip, c.my_hw, c.my_ip, 1'b1);
      r0.last = 1'b1;
      return 1;
    end
    r0 = binding(it.sender_ip, it.sender_hw);
    if (it.arp_op == ARP_OP_REQUEST) begin
      proxy_hit = c.proxy_enable &&
                  classful_net(it.target_ip) == classful_net(c.my_ip) &&
                  subnet_of(it.target_ip, c.subnet_mask) != subnet_of(c.my_ip, c.subnet_mask);
      if (it.target_ip == c.my_ip || proxy_hit) begin
        r1 = arp_frame(HW_BROADCAST, OUT_OP_REPLY, c.my_hw, it.target_ip, it.sender_hw,
                       it.sender_ip, 1'b0);
        r1.last = 1'b1;
        return 2;
      end
      if ((it.target_ip == c.peer_ip || it.target_ip == c.broadcast_ip) && c.fool_enable) begin
        r1 = arp_frame(it.frame_src_hw, OUT_OP_REPLY, '0, it.target_ip, it.sender_hw,
                       it.sender_ip, 1'b0);
        r1.last = 1'b1;
        return 2;
      end
    end
    r0.last = 1'b1;
    return 1;
  endfunction

  function automatic in_item_t mk_query(input logic [31:0] tip, input logic junk);
    in_item_t it;
    it = junk ? '1 : '0;
    it.action    = ACTION_QUERY;
    it.target_ip = tip;
    return it;
  endfunction

  function automatic in_item_t mk_frame(input logic [15:0] op, input logic [15:0] proto,
                                        input logic [47:0] shw, input logic [31:0] sip,
                                        input logic [31:0] tip, input logic [47:0] fsrc);
    in_item_t it;
    it.action       = ACTION_FRAME;
    it.arp_op       = op;
    it.protocol     = proto;
    it.sender_hw    = shw;
    it.sender_ip    = sip;
    it.target_ip    = tip;
    it.frame_src_hw = fsrc;
    return it;
  endfunction

  // addresses near our own, the special ones, or anything
  function automatic logic [31:0] pick_ip(input cfg_t c);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 6))
      0: return c.my_ip;
      1: return c.peer_ip;
      2: return c.broadcast_ip;
      3: return c.my_ip ^ (r >> 24);
      4: return c.my_ip ^ (r >> 16);
      5: return c.my_ip ^ (r >> 8);
      default: return r;
    endcase
  endfunction

  // mostly well-formed IP frames and queries, some noise
  function automatic in_item_t random_item(input cfg_t c);
    in_item_t it;
    int pick;
    int opsel;
    it.action       = ACTION_FRAME;
    it.arp_op       = 16'($urandom);
    it.protocol     = 16'($urandom);
    it.sender_hw    = rand48();
    it.sender_ip    = $urandom;
    it.target_ip    = $urandom;
    it.frame_src_hw = rand48();
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      it.action    = ACTION_QUERY;
      it.target_ip = pick_ip(c);
    end else if (pick < 85) begin
      it.protocol = PROTO_IP;
      opsel = $urandom_range(0, 9);
      if (opsel < 6) it.arp_op = ARP_OP_REQUEST;
      else if (opsel < 9) it.arp_op = ARP_OP_REPLY;
      if ($urandom_range(0, 9) == 0) it.sender_hw = c.my_hw;
      if ($urandom_range(0, 9) == 0) it.sender_ip = c.my_ip;
      it.target_ip = pick_ip(c);
    end else begin
      it.action = 1'($urandom);
    end
    return it;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.my_ip = $urandom;
    case ($urandom_range(0, 3))
      0: c.my_ip[31] = 1'b0;
      1: c.my_ip[31:30] = 2'b10;
      2: c.my_ip[31:29] = 3'b110;
      default: c.my_ip[31:29] = 3'b111;
    endcase
    c.my_hw        = rand48();
    c.peer_ip      = c.my_ip ^ 32'($urandom_range(1, 255));
    c.broadcast_ip = ($urandom_range(0, 1) == 0) ? (c.my_ip | 32'h0000_00FF) : $urandom;
    c.subnet_mask  = ($urandom_range(0, 3) == 0) ? '0 :
                     ~(32'hFFFF_FFFF >> $urandom_range(0, 32));
    c.proxy_enable = 1'($urandom_range(0, 1));
    c.fool_enable  = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Write every register, plus the unused index; call right after a rising edge
  task automatic write_cfg(input cfg_t c);
    logic [2:0]  idx;
    logic [47:0] val;
    for (int i = 0; i < 8; i++) begin
      idx = 3'(i);
      case (idx)
        CFG_MY_IP:        val = 48'(c.my_ip);
        CFG_MY_HW:        val = c.my_hw;
        CFG_PEER_IP:      val = 48'(c.peer_ip);
        CFG_BROADCAST_IP: val = 48'(c.broadcast_ip);
        CFG_SUBNET_MASK:  val = 48'(c.subnet_mask);
        CFG_PROXY_ENABLE: val = 48'(c.proxy_enable);
        CFG_FOOL_ENABLE:  val = 48'(c.fool_enable);
        CFG_UNUSED:       val = rand48();
        default:          val = '0;
      endcase
      cfg_index <= idx;
      cfg_data  <= val;
      if (i == 0) cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cfg_now = c;
  endtask

  task automatic start_phase(input cfg_t c, input int send_pct, input int recv_pct);
    write_cfg(c);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // all items taken, all results in, then let trailing work settle
  task automatic finish_phase();
    do @(negedge clk);
    while (arp_inputs_q.size() != 0 || item_valid || arp_results_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Item driver
  always @(posedge clk) begin : drive
    out_item_t r0, r1;
    int n;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        n = predict_arp(item, cfg_now, r0, r1);
        if (n >= 1) arp_results_q.push_back(r0);
        if (n == 2) arp_results_q.push_back(r1);
      end
      if (!item_valid || !item_stall) begin
        if (arp_inputs_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item       <= arp_inputs_q.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin : watch
    out_item_t want;
    string diffs;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (arp_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected result %0d: got %h", results_seen, result);
        end else begin
          want  = arp_results_q.pop_front();
          diffs = "";
          if (result.kind !== want.kind) diffs = {diffs, " kind"};
          if (result.eth_dest !== want.eth_dest) diffs = {diffs, " eth_dest"};
          if (result.out_op !== want.out_op) diffs = {diffs, " out_op"};
          if (result.out_sender_hw !== want.out_sender_hw) diffs = {diffs, " out_sender_hw"};
          if (result.out_sender_ip !== want.out_sender_ip) diffs = {diffs, " out_sender_ip"};
          if (result.out_target_hw !== want.out_target_hw) diffs = {diffs, " out_target_hw"};
          if (result.out_target_ip !== want.out_target_ip) diffs = {diffs, " out_target_ip"};
          if (result.bind_ip !== want.bind_ip) diffs = {diffs, " bind_ip"};
          if (result.bind_hw !== want.bind_hw) diffs = {diffs, " bind_hw"};
          if (result.forgery_alert !== want.forgery_alert) diffs = {diffs, " forgery_alert"};
          if (result.last !== want.last) diffs = {diffs, " last"};
          if (diffs != "") begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
              $display("result %0d differs in%s", results_seen, diffs);
              $display("  expected %h", want);
              $display("  actual   %h", result);
            end
          end
        end
      end
      // long hold-off when asked, random stalls otherwise
      if (holdoff_left == 0 && pressure_req != pressure_done) begin
        holdoff_left = HOLDOFF_LEN;
        pressure_done++;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : main
    cfg_t c;
    logic [47:0] h1;
    logic [47:0] s1;
    h1 = 48'h0A0B_0C0D_0E0F;
    s1 = 48'h0200_0000_0042;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: class A address, /24 subnet, proxy and fool replies on
    c.my_ip        = 32'h0A01_0203;
    c.my_hw        = 48'h0200_5E10_2030;
    c.peer_ip      = 32'h0A01_02FE;
    c.broadcast_ip = 32'h0A01_02FF;
    c.subnet_mask  = 32'hFFFF_FF00;
    c.proxy_enable = 1'b1;
    c.fool_enable  = 1'b1;
    start_phase(c, 27, 77);
    arp_inputs_q.push_back(mk_query(c.my_ip, 1'b0));
    arp_inputs_q.push_back(mk_query(c.peer_ip, 1'b1));
    arp_inputs_q.push_back(mk_query(c.broadcast_ip, 1'b0));
    arp_inputs_q.push_back(mk_query(32'hC0A8_0001, 1'b1));
    arp_inputs_q.push_back(mk_query(32'h0000_0000, 1'b0));
    arp_inputs_q.push_back(mk_query(32'hFFFF_FFFF, 1'b1));
    // non-IP protocols are dropped
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, PROTO_IPV6, h1, 32'h0A01_0209, c.my_ip, s1));
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, 16'hFFFF, h1, 32'h0A01_0209, c.my_ip, s1));
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, 16'h0000, h1, 32'h0A01_0209, c.my_ip, s1));
    // address forgery under several opcodes
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, PROTO_IP, h1, c.my_ip, 32'h0A01_0209, s1));
    arp_inputs_q.push_back(mk_frame(ARP_OP_REPLY, PROTO_IP, h1, c.my_ip, 32'h0A01_0209, s1));
    arp_inputs_q.push_back(mk_frame(16'hFFFF, PROTO_IP, 48'hFFFF_FFFF_FFFF, c.my_ip, '0, '0));
    // our own address and hardware: no forgery
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, PROTO_IP, c.my_hw, c.my_ip, c.my_ip, s1));
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, PROTO_IP, h1, 32'h0A01_0209, c.my_ip, s1));
    // proxy target, same subnet, other net
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, PROTO_IP, h1, 32'h0A01_0209, 32'h0A07_0707, s1));
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, PROTO_IP, h1, 32'h0A01_0209, 32'h0A01_024D, s1));
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, PROTO_IP, h1, 32'h0A01_0209, 32'h0B00_0001, s1));
    // fool replies for peer and broadcast
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, PROTO_IP, h1, 32'h0A01_0209, c.peer_ip, s1));
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, PROTO_IP, h1, 32'h0A01_0209,
                                    c.broadcast_ip, 48'hFFFF_FFFF_FFFF));
    // non-request opcodes and field extremes
    arp_inputs_q.push_back(mk_frame(ARP_OP_REPLY, PROTO_IP, h1, 32'h0A01_0209, c.my_ip, s1));
    arp_inputs_q.push_back(mk_frame(16'h0000, PROTO_IP, '0, '0, c.my_ip, '0));
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, PROTO_IP, 48'hFFFF_FFFF_FFFF,
                                    32'hFFFF_FFFF, 32'h0000_0000, '0));
    finish_phase();

    // same targets with proxy and fool disabled: binding only
    c.proxy_enable = 1'b0;
    c.fool_enable  = 1'b0;
    start_phase(c, 27, 77);
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, PROTO_IP, h1, 32'h0A01_0209, 32'h0A07_0707, s1));
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, PROTO_IP, h1, 32'h0A01_0209, c.peer_ip, s1));
    arp_inputs_q.push_back(mk_frame(ARP_OP_REQUEST, PROTO_IP, h1, 32'h0A01_0209,
                                    c.broadcast_ip, s1));
    finish_phase();

    // Random phases: all-zero and all-one registers first, then random settings
    for (int p = 0; p < 6; p++) begin
      if (p == 0) c = '0;
      else if (p == 1) c = '1;
      else c = random_cfg();
      if (p < 2) start_phase(c, 27, 77);
      else if (p < 4) start_phase(c, 77, 27);
      else start_phase(c, 0, 0);
      repeat (ITEMS_PER_PHASE) arp_inputs_q.push_back(random_item(cfg_now));
      if (p == 4) pressure_req++;
      finish_phase();
    end

    if (mismatches == 0 && arp_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/arp_pkg.sv
hdl/arp_decide.sv
hdl/arp_responder_unit.sv
bench/arp_responder_unit_test.sv
